FILE: hdl/ifd_pkg.sv
package ifd_pkg;

	localparam logic [7:0] FLAG_BYTE     = 8'h7E;
	localparam logic [7:0] ESC_BYTE      = 8'h7D;
	localparam logic [7:0] ESC_FLAG_CODE = 8'h5E;
	localparam logic [7:0] ESC_ESC_CODE  = 8'h5D;

	localparam logic [7:0] RST_ADDRESS    = 8'h03;
	localparam logic [7:0] RST_CTRL_SEQ0  = 8'h00;
	localparam logic [7:0] RST_CTRL_SEQ1  = 8'h40;
	localparam logic [7:0] RST_DISC_CTRL  = 8'h0B;

	localparam logic [1:0] REG_ADDRESS   = 2'd0;
	localparam logic [1:0] REG_CTRL_SEQ0 = 2'd1;
	localparam logic [1:0] REG_CTRL_SEQ1 = 2'd2;
	localparam logic [1:0] REG_DISC_CTRL = 2'd3;

	localparam logic [1:0] KIND_DATA   = 2'd0;
	localparam logic [1:0] KIND_ACCEPT = 2'd1;
	localparam logic [1:0] KIND_REJECT = 2'd2;
	localparam logic [1:0] KIND_DISC   = 2'd3;

	localparam int RES_DEPTH = 4;

	typedef struct packed {
		logic [7:0] address_byte;
		logic [7:0] control_seq0;
		logic [7:0] control_seq1;
		logic [7:0] disconnect_control;
	} cfg_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  payload_byte;
		logic [11:0] payload_length;
		logic        response_sequence;
		logic        last_of_run;
	} res_t;

endpackage

FILE: hdl/ifd_parser.sv
module ifd_parser #(
	parameter int LENGTH_BITS = 12
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             take,
	input  logic [7:0]       byte_s1,
	input  ifd_pkg::cfg_t    cfg,
	output logic [1:0]       push_n,
	output ifd_pkg::res_t    res0,
	output ifd_pkg::res_t    res1
);

	typedef enum logic [2:0] {
		ST_HUNT,
		ST_FLAG,
		ST_ADDR,
		ST_CTRL,
		ST_DATA,
		ST_ESC
	} state_t;

	localparam logic [LENGTH_BITS-1:0] CNT_MAX = {LENGTH_BITS{1'b1}};

	function automatic logic [LENGTH_BITS-1:0] sat_inc(input logic [LENGTH_BITS-1:0] v);
		return (v == CNT_MAX) ? v : v + 1'b1;
	endfunction

	state_t                 st_q, st_d;
	logic [7:0]             ctl_q, ctl_d;
	logic [7:0]             held_q, held_d;
	logic                   hv_q, hv_d;
	logic [7:0]             xor_q, xor_d;
	logic [LENGTH_BITS-1:0] cnt_q, cnt_d;
	logic                   seq_q, seq_d;
	logic                   push_one;
	logic [7:0]             push_val;
	logic                   finish;
	logic                   good;

	always_comb begin
		st_d     = st_q;
		ctl_d    = ctl_q;
		held_d   = held_q;
		hv_d     = hv_q;
		xor_d    = xor_q;
		cnt_d    = cnt_q;
		seq_d    = seq_q;
		push_n   = 2'd0;
		res0     = '0;
		res1     = '0;
		push_one = 1'b0;
		push_val = byte_s1;
		finish   = 1'b0;
		good     = 1'b0;
		if (take) begin
			case (st_q)
				ST_HUNT: begin
					if (byte_s1 == ifd_pkg::FLAG_BYTE) st_d = ST_FLAG;
				end
				ST_FLAG: begin
					if (byte_s1 == cfg.address_byte) st_d = ST_ADDR;
					else if (byte_s1 != ifd_pkg::FLAG_BYTE) st_d = ST_HUNT;
				end
				ST_ADDR: begin
					if (byte_s1 == cfg.control_seq0 || byte_s1 == cfg.control_seq1) begin
						ctl_d = byte_s1;
						st_d  = ST_CTRL;
					end else if (byte_s1 == ifd_pkg::FLAG_BYTE) begin
						st_d = ST_FLAG;
					end else if (byte_s1 == cfg.disconnect_control) begin
						res0.kind = ifd_pkg::KIND_DISC;
						push_n    = 2'd1;
						st_d      = ST_HUNT;
					end else begin
						st_d = ST_HUNT;
					end
				end
				ST_CTRL: begin
					if (byte_s1 == (cfg.address_byte ^ ctl_q)) begin
						hv_d   = 1'b0;
						held_d = '0;
						xor_d  = '0;
						cnt_d  = '0;
						st_d   = ST_DATA;
					end else if (byte_s1 == ifd_pkg::FLAG_BYTE) begin
						st_d = ST_FLAG;
					end else begin
						st_d = ST_HUNT;
					end
				end
				ST_DATA: begin
					if (byte_s1 == ifd_pkg::ESC_BYTE) begin
						st_d = ST_ESC;
					end else if (byte_s1 == ifd_pkg::FLAG_BYTE) begin
						finish = 1'b1;
						good   = hv_q && (held_q == xor_q);
					end else begin
						push_one = 1'b1;
					end
				end
				ST_ESC: begin
					st_d = ST_DATA;
					if (byte_s1 == ifd_pkg::ESC_FLAG_CODE) begin
						push_one = 1'b1;
						push_val = ifd_pkg::FLAG_BYTE;
					end else if (byte_s1 == ifd_pkg::ESC_ESC_CODE) begin
						push_one = 1'b1;
						push_val = ifd_pkg::ESC_BYTE;
					end else if (byte_s1 == ifd_pkg::FLAG_BYTE) begin
						finish = 1'b1;
					end else begin
						// unknown escape: ESC goes through as data, then the byte is held
						if (hv_q) begin
							res0.payload_byte = held_q;
							res1.payload_byte = ifd_pkg::ESC_BYTE;
							push_n = 2'd2;
							xor_d  = xor_q ^ held_q ^ ifd_pkg::ESC_BYTE;
							cnt_d  = sat_inc(sat_inc(cnt_q));
						end else begin
							res0.payload_byte = ifd_pkg::ESC_BYTE;
							push_n = 2'd1;
							xor_d  = xor_q ^ ifd_pkg::ESC_BYTE;
							cnt_d  = sat_inc(cnt_q);
						end
						held_d = byte_s1;
						hv_d   = 1'b1;
					end
				end
				default: st_d = ST_HUNT;
			endcase

			if (push_one) begin
				if (hv_q) begin
					res0.payload_byte = held_q;
					push_n = 2'd1;
					xor_d  = xor_q ^ held_q;
					cnt_d  = sat_inc(cnt_q);
				end
				held_d = push_val;
				hv_d   = 1'b1;
			end

			if (finish) begin
				res0.kind              = good ? ifd_pkg::KIND_ACCEPT : ifd_pkg::KIND_REJECT;
				res0.payload_length    = 12'(cnt_q);
				res0.response_sequence = seq_q;
				push_n = 2'd1;
				if (good) seq_d = ~seq_q;
				hv_d = 1'b0;
				st_d = ST_HUNT;
			end

			if (push_n == 2'd1) res0.last_of_run = 1'b1;
			if (push_n == 2'd2) res1.last_of_run = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= ST_HUNT;
			ctl_q  <= '0;
			held_q <= '0;
			hv_q   <= 1'b0;
			xor_q  <= '0;
			cnt_q  <= '0;
			seq_q  <= 1'b1;
		end else begin
			st_q   <= st_d;
			ctl_q  <= ctl_d;
			held_q <= held_d;
			hv_q   <= hv_d;
			xor_q  <= xor_d;
			cnt_q  <= cnt_d;
			seq_q  <= seq_d;
		end
	end

endmodule

FILE: hdl/ifd_result_fifo.sv
module ifd_result_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [1:0]    push_n,
	input  ifd_pkg::res_t wr0,
	input  ifd_pkg::res_t wr1,
	input  logic          pop,
	output logic          not_empty,
	output logic          room,
	output ifd_pkg::res_t head
);

	localparam int PW = $clog2(ifd_pkg::RES_DEPTH);
	localparam int CW = $clog2(ifd_pkg::RES_DEPTH + 1);
	localparam logic [CW-1:0] ROOM_MAX = CW'(ifd_pkg::RES_DEPTH - 2);

	ifd_pkg::res_t mem_q [ifd_pkg::RES_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] cnt_q;

	assign not_empty = (cnt_q != '0);
	assign room      = (cnt_q <= ROOM_MAX);
	assign head      = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push_n != 2'd0) mem_q[wr_ptr_q] <= wr0;
		if (push_n == 2'd2) mem_q[wr_ptr_q + 1'b1] <= wr1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PW'(push_n);
			if (pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			cnt_q <= cnt_q + CW'(push_n) - CW'(pop);
		end
	end

endmodule

FILE: hdl/info_frame_deframer.sv
// channel | direction | handshake              | payload
// in      | input     | in_valid / in_ready    | line_byte
// out     | output    | out_valid / out_ready  | kind, payload_byte, payload_length,
//         |           |                        | response_sequence, last_of_run
// cfg     | input     | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// A byte is parsed from the input register while the queue has room; its results
// enter a four-entry result queue and are presented at the port from its head.
// One byte per cycle while the queue has room; the output port moves one result per
// cycle while out_ready is high, so a byte that makes two results takes two transfers.
// The input register holds while the queue has fewer than two free entries.
// Reset empties the queue and sets parser state (sequence bit to 1) and configuration to defaults at once.
module info_frame_deframer #(
	parameter int LENGTH_BITS = 12
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  line_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  kind,
	output logic [7:0]  payload_byte,
	output logic [11:0] payload_length,
	output logic        response_sequence,
	output logic        last_of_run,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data
);

	ifd_pkg::cfg_t cfg_q;
	logic          in_valid_s1;
	logic [7:0]    byte_s1;
	logic          take;
	logic          room;
	logic [1:0]    push_n;
	ifd_pkg::res_t res0;
	ifd_pkg::res_t res1;
	ifd_pkg::res_t head;

	assign cfg_ready = 1'b1;
	assign take      = in_valid_s1 && room;
	assign in_ready  = !in_valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.address_byte       <= ifd_pkg::RST_ADDRESS;
			cfg_q.control_seq0       <= ifd_pkg::RST_CTRL_SEQ0;
			cfg_q.control_seq1       <= ifd_pkg::RST_CTRL_SEQ1;
			cfg_q.disconnect_control <= ifd_pkg::RST_DISC_CTRL;
		end else if (cfg_valid) begin
			case (cfg_index)
				ifd_pkg::REG_ADDRESS:   cfg_q.address_byte       <= cfg_data;
				ifd_pkg::REG_CTRL_SEQ0: cfg_q.control_seq0       <= cfg_data;
				ifd_pkg::REG_CTRL_SEQ1: cfg_q.control_seq1       <= cfg_data;
				ifd_pkg::REG_DISC_CTRL: cfg_q.disconnect_control <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (in_ready) begin
			in_valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) byte_s1 <= line_byte;
	end

	ifd_parser #(
		.LENGTH_BITS(LENGTH_BITS)
	) u_parser (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (take),
		.byte_s1(byte_s1),
		.cfg    (cfg_q),
		.push_n (push_n),
		.res0   (res0),
		.res1   (res1)
	);

	ifd_result_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push_n   (push_n),
		.wr0      (res0),
		.wr1      (res1),
		.pop      (out_valid && out_ready),
		.not_empty(out_valid),
		.room     (room),
		.head     (head)
	);

	assign kind              = head.kind;
	assign payload_byte      = head.payload_byte;
	assign payload_length    = head.payload_length;
	assign response_sequence = head.response_sequence;
	assign last_of_run       = head.last_of_run;

`ifndef SYNTH
	a_push_needs_take: assert property (@(posedge clk) disable iff (!arst_n)
		push_n != 2'd0 |-> take)
		else $error("results pushed without a parsed byte");

	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		push_n == 2'd1 |-> res0.last_of_run)
		else $error("single result without last mark");

	a_pair_last: assert property (@(posedge clk) disable iff (!arst_n)
		push_n == 2'd2 |-> (res1.last_of_run && !res0.last_of_run &&
			res0.kind == ifd_pkg::KIND_DATA && res1.kind == ifd_pkg::KIND_DATA))
		else $error("bad last mark on result pair");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> in_valid_s1 && !room)
		else $error("input stalled with nothing pending");
`endif

endmodule
